// ----- src/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment/triangle crossing counter package
// Shared constants, register indexes and the flag struct between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stc_pkg;

	// Default field widths.
	localparam int COORD_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 16;

	// Crossing fraction is unsigned Q0.16, one quotient bit per divider step.
	localparam int FRAC_WIDTH = 16;

	// Entries of the queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	localparam int REG_INDEX_WIDTH = 3;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_START_X = 3'd0;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_START_Y = 3'd1;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_START_Z = 3'd2;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_SPAN_X  = 3'd3;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_SPAN_Y  = 3'd4;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_SPAN_Z  = 3'd5;

	// Classification flags of one triangle.
	typedef struct packed {
		logic hit;
		logic from_front;
		logic last;
	} flags_t;

endpackage

// ----- src/stc_front.sv -----
// ----------------------------------------------------------------------------
// Crossing classifier
// Three-stage pipeline: vertex differences, cross products, dot products,
// then the straddle and inside tests that form one queue request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stc_front #(
	parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF,
	parameter int MAG_WIDTH   = 3 * stc_pkg::COORD_WIDTH_DEF + 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] span_x,
	input  logic signed [COORD_WIDTH-1:0] span_y,
	input  logic signed [COORD_WIDTH-1:0] span_z,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] a_z,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] b_z,
	input  logic signed [COORD_WIDTH-1:0] c_x,
	input  logic signed [COORD_WIDTH-1:0] c_y,
	input  logic signed [COORD_WIDTH-1:0] c_z,
	input  logic                          final_triangle,
	output logic                          push,
	input  logic                          queue_full,
	output stc_pkg::flags_t               push_flags,
	output logic [MAG_WIDTH-1:0]          push_mag0,
	output logic [MAG_WIDTH-1:0]          push_magn
);

	localparam int EW = COORD_WIDTH + 1;
	localparam int NW = 2 * COORD_WIDTH + 3;
	localparam int DW = MAG_WIDTH;

	// One component of a cross product: p*q - r*s.
	function automatic logic signed [NW-1:0] xterm(
		input logic signed [EW-1:0] p,
		input logic signed [EW-1:0] q,
		input logic signed [EW-1:0] r,
		input logic signed [EW-1:0] s
	);
		xterm = NW'(p) * NW'(q) - NW'(r) * NW'(s);
	endfunction

	// Dot product of a cross-product vector with a difference vector.
	function automatic logic signed [DW-1:0] dterm(
		input logic signed [NW-1:0] nx,
		input logic signed [NW-1:0] ny,
		input logic signed [NW-1:0] nz,
		input logic signed [EW-1:0] vx,
		input logic signed [EW-1:0] vy,
		input logic signed [EW-1:0] vz
	);
		dterm = DW'(nx) * DW'(vx) + DW'(ny) * DW'(vy) + DW'(nz) * DW'(vz);
	endfunction

	logic pipe_en;
	logic v_s1, v_s2, v_s3;
	logic fin_s1, fin_s2, fin_s3;

	logic signed [EW-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [EW-1:0] sax_s1, say_s1, saz_s1;
	logic signed [EW-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1, wx_s1, wy_s1, wz_s1;

	logic signed [NW-1:0] nx_s2, ny_s2, nz_s2;
	logic signed [NW-1:0] p1x_s2, p1y_s2, p1z_s2, p2x_s2, p2y_s2, p2z_s2;
	logic signed [NW-1:0] p3x_s2, p3y_s2, p3z_s2;
	logic signed [EW-1:0] sax_s2, say_s2, saz_s2;

	logic signed [DW-1:0] d0_s3, nd_s3, t1_s3, t2_s3, t3_s3;

	logic signed [EW-1:0] dx, dy, dz;
	logic signed [DW:0]   d1;
	logic                 straddle, nd_pos, nd_neg, outside;

	// The whole pipeline holds while a finished request cannot enter the queue.
	assign pipe_en  = !(v_s3 && queue_full);
	assign in_stall = !pipe_en;
	assign push     = v_s3 && !queue_full;

	assign dx = EW'(span_x);
	assign dy = EW'(span_y);
	assign dz = EW'(span_z);

	// Valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: edge vectors and vertex offsets from the segment start.
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fin_s1 <= final_triangle;
			e1x_s1 <= EW'(b_x) - EW'(a_x);
			e1y_s1 <= EW'(b_y) - EW'(a_y);
			e1z_s1 <= EW'(b_z) - EW'(a_z);
			e2x_s1 <= EW'(c_x) - EW'(a_x);
			e2y_s1 <= EW'(c_y) - EW'(a_y);
			e2z_s1 <= EW'(c_z) - EW'(a_z);
			sax_s1 <= EW'(start_x) - EW'(a_x);
			say_s1 <= EW'(start_y) - EW'(a_y);
			saz_s1 <= EW'(start_z) - EW'(a_z);
			ux_s1  <= EW'(a_x) - EW'(start_x);
			uy_s1  <= EW'(a_y) - EW'(start_y);
			uz_s1  <= EW'(a_z) - EW'(start_z);
			vx_s1  <= EW'(b_x) - EW'(start_x);
			vy_s1  <= EW'(b_y) - EW'(start_y);
			vz_s1  <= EW'(b_z) - EW'(start_z);
			wx_s1  <= EW'(c_x) - EW'(start_x);
			wy_s1  <= EW'(c_y) - EW'(start_y);
			wz_s1  <= EW'(c_z) - EW'(start_z);
		end
	end

	// Stage 2: plane normal and the cross products of each pair of vertex offsets.
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fin_s2 <= fin_s1;
			nx_s2  <= xterm(e1y_s1, e2z_s1, e1z_s1, e2y_s1);
			ny_s2  <= xterm(e1z_s1, e2x_s1, e1x_s1, e2z_s1);
			nz_s2  <= xterm(e1x_s1, e2y_s1, e1y_s1, e2x_s1);
			p1x_s2 <= xterm(uy_s1, vz_s1, uz_s1, vy_s1);
			p1y_s2 <= xterm(uz_s1, vx_s1, ux_s1, vz_s1);
			p1z_s2 <= xterm(ux_s1, vy_s1, uy_s1, vx_s1);
			p2x_s2 <= xterm(vy_s1, wz_s1, vz_s1, wy_s1);
			p2y_s2 <= xterm(vz_s1, wx_s1, vx_s1, wz_s1);
			p2z_s2 <= xterm(vx_s1, wy_s1, vy_s1, wx_s1);
			p3x_s2 <= xterm(wy_s1, uz_s1, wz_s1, uy_s1);
			p3y_s2 <= xterm(wz_s1, ux_s1, wx_s1, uz_s1);
			p3z_s2 <= xterm(wx_s1, uy_s1, wy_s1, ux_s1);
			sax_s2 <= sax_s1;
			say_s2 <= say_s1;
			saz_s2 <= saz_s1;
		end
	end

	// Stage 3: plane distances and triple products.
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fin_s3 <= fin_s2;
			d0_s3  <= dterm(nx_s2, ny_s2, nz_s2, sax_s2, say_s2, saz_s2);
			nd_s3  <= dterm(nx_s2, ny_s2, nz_s2, dx, dy, dz);
			t1_s3  <= dterm(p1x_s2, p1y_s2, p1z_s2, dx, dy, dz);
			t2_s3  <= dterm(p2x_s2, p2y_s2, p2z_s2, dx, dy, dz);
			t3_s3  <= dterm(p3x_s2, p3y_s2, p3z_s2, dx, dy, dz);
		end
	end

	// Straddle test, inside test and magnitudes for the divider.
	always_comb begin
		d1       = (DW + 1)'(d0_s3) + (DW + 1)'(nd_s3);
		straddle = (d0_s3[DW-1] && !d1[DW] && (d1 != '0))
			|| (!d0_s3[DW-1] && (d0_s3 != '0) && d1[DW]);
		nd_pos   = !nd_s3[DW-1] && (nd_s3 != '0);
		nd_neg   = nd_s3[DW-1];
		outside  = (t1_s3[DW-1] && nd_pos) || (!t1_s3[DW-1] && (t1_s3 != '0) && nd_neg)
			|| (t2_s3[DW-1] && nd_pos) || (!t2_s3[DW-1] && (t2_s3 != '0) && nd_neg)
			|| (t3_s3[DW-1] && nd_pos) || (!t3_s3[DW-1] && (t3_s3 != '0) && nd_neg);
		push_flags.hit        = straddle && !outside;
		push_flags.from_front = d0_s3[DW-1];
		push_flags.last       = fin_s3;
		push_mag0 = d0_s3[DW-1] ? MAG_WIDTH'(-d0_s3) : MAG_WIDTH'(d0_s3);
		push_magn = nd_s3[DW-1] ? MAG_WIDTH'(-nd_s3) : MAG_WIDTH'(nd_s3);
	end

endmodule

// ----- src/stc_queue.sv -----
// ----------------------------------------------------------------------------
// Classified-triangle queue
// Small register FIFO that decouples the classifier from the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stc_queue #(
	parameter int MAG_WIDTH = 3 * stc_pkg::COORD_WIDTH_DEF + 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  stc_pkg::flags_t      push_flags,
	input  logic [MAG_WIDTH-1:0] push_mag0,
	input  logic [MAG_WIDTH-1:0] push_magn,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output stc_pkg::flags_t      head_flags,
	output logic [MAG_WIDTH-1:0] head_mag0,
	output logic [MAG_WIDTH-1:0] head_magn
);

	localparam int DEPTH = stc_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	stc_pkg::flags_t      flags_q [DEPTH];
	logic [MAG_WIDTH-1:0] mag0_q  [DEPTH];
	logic [MAG_WIDTH-1:0] magn_q  [DEPTH];
	logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [PW:0]          fill_q;

	assign full       = (fill_q == (PW + 1)'(DEPTH));
	assign empty      = (fill_q == '0);
	assign head_flags = flags_q[rd_ptr_q];
	assign head_mag0  = mag0_q[rd_ptr_q];
	assign head_magn  = magn_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			flags_q[wr_ptr_q] <= push_flags;
			mag0_q[wr_ptr_q]  <= push_mag0;
			magn_q[wr_ptr_q]  <= push_magn;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

// ----- src/stc_back.sv -----
// ----------------------------------------------------------------------------
// Crossing fraction divider and hit counter
// Restoring divider, one quotient bit per cycle, plus the saturating per-mesh
// hit count and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stc_back #(
	parameter int COUNT_WIDTH = stc_pkg::COUNT_WIDTH_DEF,
	parameter int MAG_WIDTH   = 3 * stc_pkg::COORD_WIDTH_DEF + 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                empty,
	output logic                                pop,
	input  stc_pkg::flags_t                     head_flags,
	input  logic [MAG_WIDTH-1:0]                head_mag0,
	input  logic [MAG_WIDTH-1:0]                head_magn,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic [stc_pkg::FRAC_WIDTH-1:0]      cross_fraction,
	output logic                                from_front,
	output logic [COUNT_WIDTH-1:0]              running_hits,
	output logic                                mesh_end,
	output logic                                odd_hits
);

	localparam int FW = stc_pkg::FRAC_WIDTH;
	localparam int SW = $clog2(FW);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic [MAG_WIDTH-1:0] rem_q, den_q;
	logic [FW-1:0]        quot_q;
	logic [SW-1:0]        step_q;
	stc_pkg::flags_t      flags_q;
	logic [COUNT_WIDTH-1:0] total_q;

	logic                 slot_free, emit, emit_hit;
	logic [MAG_WIDTH:0]   rem2, diff;
	logic                 q_bit;
	logic [COUNT_WIDTH-1:0] count_next;
	stc_pkg::flags_t      emit_flags;

	assign slot_free = !out_valid || !out_stall;
	assign pop       = (state_q == ST_IDLE) && !empty && slot_free;

	// A miss leaves straight from the queue head; a hit leaves after division.
	assign emit       = (pop && !head_flags.hit) || ((state_q == ST_DONE) && slot_free);
	assign emit_flags = (state_q == ST_DONE) ? flags_q : head_flags;
	assign emit_hit   = (state_q == ST_DONE);

	// One restoring division step.
	always_comb begin
		rem2  = {rem_q, 1'b0};
		diff  = rem2 - {1'b0, den_q};
		q_bit = !diff[MAG_WIDTH];
	end

	// Saturating hit count including the item being emitted.
	always_comb begin
		count_next = total_q;
		if (emit_hit && (total_q != '1))
			count_next = total_q + 1'b1;
	end

	// Sequencer and divider datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && head_flags.hit) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == SW'(FW - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q   <= head_mag0;
			den_q   <= head_magn;
			flags_q <= head_flags;
		end else if (state_q == ST_DIV) begin
			rem_q  <= q_bit ? diff[MAG_WIDTH-1:0] : rem2[MAG_WIDTH-1:0];
			quot_q <= {quot_q[FW-2:0], q_bit};
		end
	end

	// Per-mesh hit total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			total_q <= '0;
		else if (emit)
			total_q <= emit_flags.last ? '0 : count_next;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (emit)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			hit            <= emit_hit;
			cross_fraction <= emit_hit ? quot_q : '0;
			from_front     <= emit_hit && emit_flags.from_front;
			running_hits   <= count_next;
			mesh_end       <= emit_flags.last;
			odd_hits       <= count_next[0];
		end
	end

endmodule

// ----- src/segment_triangle_crossing_counter.sv -----
// ----------------------------------------------------------------------------
// Segment/triangle crossing counter
// Tests a stream of triangles against a configured segment and counts hits.
// ----------------------------------------------------------------------------
// Usage: write the segment start and span through wr_en/wr_index/wr_data while
// the block is idle. Triangles enter on in_valid/in_stall, one request per
// accepted edge; each request yields exactly one result on out_valid/out_stall.
// A miss passes the classifier stages, the queue and the output register;
// a hit also passes a divider that resolves one quotient bit per cycle.
// Misses stream at one per cycle while the divider is idle and the output
// is not stalled; each hit holds the divider. A three-stage classifier feeds a
// four-entry queue, so triangles keep entering while the divider is busy.
// When the receiver stalls, the output holds and the queue fills; once it is
// full the classifier holds and in_stall rises. Reset clears the segment
// registers, the hit count and all valid flags. The hit count clears after
// the result of a triangle marked final_triangle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_triangle_crossing_counter #(
	parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = stc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [stc_pkg::REG_INDEX_WIDTH-1:0]   wr_index,
	input  logic [COORD_WIDTH-1:0]                wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [COORD_WIDTH-1:0]         a_x,
	input  logic signed [COORD_WIDTH-1:0]         a_y,
	input  logic signed [COORD_WIDTH-1:0]         a_z,
	input  logic signed [COORD_WIDTH-1:0]         b_x,
	input  logic signed [COORD_WIDTH-1:0]         b_y,
	input  logic signed [COORD_WIDTH-1:0]         b_z,
	input  logic signed [COORD_WIDTH-1:0]         c_x,
	input  logic signed [COORD_WIDTH-1:0]         c_y,
	input  logic signed [COORD_WIDTH-1:0]         c_z,
	input  logic                                  final_triangle,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  hit,
	output logic [stc_pkg::FRAC_WIDTH-1:0]        cross_fraction,
	output logic                                  from_front,
	output logic [COUNT_WIDTH-1:0]                running_hits,
	output logic                                  mesh_end,
	output logic                                  odd_hits
);

	localparam int MAG_WIDTH = 3 * COORD_WIDTH + 6;

	logic signed [COORD_WIDTH-1:0] start_x_q, start_y_q, start_z_q;
	logic signed [COORD_WIDTH-1:0] span_x_q, span_y_q, span_z_q;

	logic                 push, pop, queue_full, queue_empty;
	stc_pkg::flags_t      push_flags, head_flags;
	logic [MAG_WIDTH-1:0] push_mag0, push_magn, head_mag0, head_magn;

	// Segment registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			start_z_q <= '0;
			span_x_q  <= '0;
			span_y_q  <= '0;
			span_z_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				stc_pkg::REG_START_X: start_x_q <= wr_data;
				stc_pkg::REG_START_Y: start_y_q <= wr_data;
				stc_pkg::REG_START_Z: start_z_q <= wr_data;
				stc_pkg::REG_SPAN_X:  span_x_q  <= wr_data;
				stc_pkg::REG_SPAN_Y:  span_y_q  <= wr_data;
				stc_pkg::REG_SPAN_Z:  span_z_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Classifier.
	stc_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.MAG_WIDTH   (MAG_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start_x        (start_x_q),
		.start_y        (start_y_q),
		.start_z        (start_z_q),
		.span_x         (span_x_q),
		.span_y         (span_y_q),
		.span_z         (span_z_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.a_x            (a_x),
		.a_y            (a_y),
		.a_z            (a_z),
		.b_x            (b_x),
		.b_y            (b_y),
		.b_z            (b_z),
		.c_x            (c_x),
		.c_y            (c_y),
		.c_z            (c_z),
		.final_triangle (final_triangle),
		.push           (push),
		.queue_full     (queue_full),
		.push_flags     (push_flags),
		.push_mag0      (push_mag0),
		.push_magn      (push_magn)
	);

	// Decoupling queue.
	stc_queue #(
		.MAG_WIDTH (MAG_WIDTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_flags (push_flags),
		.push_mag0  (push_mag0),
		.push_magn  (push_magn),
		.full       (queue_full),
		.pop        (pop),
		.empty      (queue_empty),
		.head_flags (head_flags),
		.head_mag0  (head_mag0),
		.head_magn  (head_magn)
	);

	// Divider, counter and output register.
	stc_back #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.MAG_WIDTH   (MAG_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (queue_empty),
		.pop            (pop),
		.head_flags     (head_flags),
		.head_mag0      (head_mag0),
		.head_magn      (head_magn),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.cross_fraction (cross_fraction),
		.from_front     (from_front),
		.running_hits   (running_hits),
		.mesh_end       (mesh_end),
		.odd_hits       (odd_hits)
	);

endmodule

// ----- bench/segment_triangle_crossing_counter_tb.sv -----
// ----------------------------------------------------------------------------
// Segment/triangle crossing counter testbench
// Drives triangle requests against several segment settings, predicts each
// result from exact wide-integer geometry and checks every field in order.
// Both sides idle at random, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_triangle_crossing_counter_tb;

	localparam int IW = stc_pkg::REG_INDEX_WIDTH;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
		logic               fin;
	} tri_t;

	typedef struct {
		logic        hit;
		logic [15:0] frac;
		logic        front;
		logic [15:0] count;
		logic        mesh_end;
		logic        odd;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [IW-1:0] wr_index = '0;
	logic [15:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] a_x = '0, a_y = '0, a_z = '0;
	logic signed [15:0] b_x = '0, b_y = '0, b_z = '0;
	logic signed [15:0] c_x = '0, c_y = '0, c_z = '0;
	logic final_triangle = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic [stc_pkg::FRAC_WIDTH-1:0] cross_fraction;
	logic from_front;
	logic [15:0] running_hits;
	logic mesh_end;
	logic odd_hits;

	// Segment registers as last written, indexed like the register map.
	logic signed [15:0] seg_reg [6];
	logic [15:0] hit_count;

	tri_t      tri_pending [$];
	crossing_t crossing_exp [$];
	int        errors = 0;
	bit        sent = 0;
	bit        no_idle = 0;
	bit        hold_req = 0;
	int        send_gap = 0;
	int        stall_gap = 0;
	int        hold_cnt = 0;

	segment_triangle_crossing_counter dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Gap lengths: mostly none or short, a few long.
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int sgn(wide_t v);
		return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
	endfunction

	// Sign-relevant value of d . (u x v).
	function automatic wide_t triple(wide_t dx, wide_t dy, wide_t dz, wide_t ux, wide_t uy,
			wide_t uz, wide_t vx, wide_t vy, wide_t vz);
		return dx * (uy * vz - uz * vy) + dy * (uz * vx - ux * vz) + dz * (ux * vy - uy * vx);
	endfunction

	// Expected result of one triangle; updates the hit count.
	function automatic crossing_t predict_crossing(tri_t t);
		wide_t sx, sy, sz, dx, dy, dz, ax, ay, az, bx, by, bz, cx, cy, cz;
		wide_t nx, ny, nz, d0, nd, num;
		crossing_t r;
		int k;
		logic is_hit;
		sx = seg_reg[stc_pkg::REG_START_X]; sy = seg_reg[stc_pkg::REG_START_Y];
		sz = seg_reg[stc_pkg::REG_START_Z];
		dx = seg_reg[stc_pkg::REG_SPAN_X]; dy = seg_reg[stc_pkg::REG_SPAN_Y];
		dz = seg_reg[stc_pkg::REG_SPAN_Z];
		ax = t.ax; ay = t.ay; az = t.az;
		bx = t.bx; by = t.by; bz = t.bz;
		cx = t.cx; cy = t.cy; cz = t.cz;
		nx = (by - ay) * (cz - az) - (bz - az) * (cy - ay);
		ny = (bz - az) * (cx - ax) - (bx - ax) * (cz - az);
		nz = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
		d0 = nx * (sx - ax) + ny * (sy - ay) + nz * (sz - az);
		nd = nx * dx + ny * dy + nz * dz;
		is_hit = (sgn(d0) * sgn(d0 + nd)) < 0;
		if (is_hit) begin
			k = sgn(nd);
			if (sgn(triple(dx, dy, dz, ax - sx, ay - sy, az - sz, bx - sx, by - sy, bz - sz)) * k < 0
				|| sgn(triple(dx, dy, dz, bx - sx, by - sy, bz - sz, cx - sx, cy - sy, cz - sz)) * k < 0
				|| sgn(triple(dx, dy, dz, cx - sx, cy - sy, cz - sz, ax - sx, ay - sy, az - sz)) * k < 0)
				is_hit = 1'b0;
		end
		r.hit = is_hit;
		r.frac = '0;
		r.front = 1'b0;
		if (is_hit) begin
			num = ((d0 < 0) ? -d0 : d0) <<< 16;
			num = num / ((nd < 0) ? -nd : nd);
			r.frac = num[15:0];
			r.front = d0 < 0;
			if (hit_count != 16'hFFFF) hit_count++;
		end
		r.count = hit_count;
		r.mesh_end = t.fin;
		r.odd = hit_count[0];
		if (t.fin) hit_count = '0;
		return r;
	endfunction

	// Random triangle with no relation to the segment.
	function automatic tri_t noise_tri();
		tri_t t;
		t.ax = 16'($urandom); t.ay = 16'($urandom); t.az = 16'($urandom);
		t.bx = 16'($urandom); t.by = 16'($urandom); t.bz = 16'($urandom);
		t.cx = 16'($urandom); t.cy = 16'($urandom); t.cz = 16'($urandom);
		t.fin = ($urandom_range(0, 19) == 0);
		return t;
	endfunction

	// Triangle placed around the segment point at k/256 of the span.
	// Kinds: 0 centroid there, 1 corner there, 2 degenerate, 3 segment in plane.
	function automatic tri_t placed_tri(int k, int kind);
		tri_t t;
		int px, py, pz, ux, uy, uz, vx, vy, vz;
		px = seg_reg[stc_pkg::REG_START_X] + (seg_reg[stc_pkg::REG_SPAN_X] * k) / 256;
		py = seg_reg[stc_pkg::REG_START_Y] + (seg_reg[stc_pkg::REG_SPAN_Y] * k) / 256;
		pz = seg_reg[stc_pkg::REG_START_Z] + (seg_reg[stc_pkg::REG_SPAN_Z] * k) / 256;
		ux = $urandom_range(0, 2047) - 1024; uy = $urandom_range(0, 2047) - 1024;
		uz = $urandom_range(0, 2047) - 1024; vx = $urandom_range(0, 2047) - 1024;
		vy = $urandom_range(0, 2047) - 1024; vz = $urandom_range(0, 2047) - 1024;
		t.ax = 16'(px + ux); t.ay = 16'(py + uy); t.az = 16'(pz + uz);
		t.bx = 16'(px + vx); t.by = 16'(py + vy); t.bz = 16'(pz + vz);
		t.cx = 16'(px - ux - vx); t.cy = 16'(py - uy - vy); t.cz = 16'(pz - uz - vz);
		case (kind)
			1: begin
				t.ax = 16'(px); t.ay = 16'(py); t.az = 16'(pz);
			end
			2: begin
				t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
			end
			3: begin
				t.ax = seg_reg[stc_pkg::REG_START_X]; t.ay = seg_reg[stc_pkg::REG_START_Y];
				t.az = seg_reg[stc_pkg::REG_START_Z];
				t.bx = 16'(px); t.by = 16'(py); t.bz = 16'(pz);
			end
			default: ;
		endcase
		t.fin = ($urandom_range(0, 19) == 0);
		return t;
	endfunction

	// Driver: take accepted requests, then offer the next one at the falling edge.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			crossing_exp.push_back(predict_crossing(tri_pending.pop_front()));
			sent = 1;
		end
	end

	always @(negedge clk) begin
		if (!in_valid || sent) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (tri_pending.size() > 0) begin
				a_x <= tri_pending[0].ax; a_y <= tri_pending[0].ay; a_z <= tri_pending[0].az;
				b_x <= tri_pending[0].bx; b_y <= tri_pending[0].by; b_z <= tri_pending[0].bz;
				c_x <= tri_pending[0].cx; c_y <= tri_pending[0].cy; c_z <= tri_pending[0].cz;
				final_triangle <= tri_pending[0].fin;
				in_valid <= 1'b1;
				send_gap = no_idle ? 0 : rand_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
		sent = 0;
	end

	// Receiver stall, with a long hold-off on request.
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 0;
			hold_cnt = 250;
			out_stall <= 1'b1;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else if (stall_gap > 0) begin
			stall_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_gap = ($urandom_range(0, 9) < 7) ? 0 : rand_gap();
		end
	end

	// Monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		crossing_t e;
		if (out_valid && !out_stall) begin
			if (crossing_exp.size() == 0) begin
				$error("result with no expectation waiting");
				errors++;
			end else begin
				e = crossing_exp.pop_front();
				if (hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, hit); errors++;
				end
				if (cross_fraction !== e.frac) begin
					$error("cross_fraction: expected %0d, got %0d", e.frac, cross_fraction);
					errors++;
				end
				if (from_front !== e.front) begin
					$error("from_front: expected %0d, got %0d", e.front, from_front); errors++;
				end
				if (running_hits !== e.count) begin
					$error("running_hits: expected %0d, got %0d", e.count, running_hits);
					errors++;
				end
				if (mesh_end !== e.mesh_end) begin
					$error("mesh_end: expected %0d, got %0d", e.mesh_end, mesh_end); errors++;
				end
				if (odd_hits !== e.odd) begin
					$error("odd_hits: expected %0d, got %0d", e.odd, odd_hits); errors++;
				end
			end
		end
	end

	task automatic write_reg(int idx, logic [15:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= IW'(idx);
		wr_data <= val;
		if (idx < 6) seg_reg[idx] = val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_segment(int sx, int sy, int sz, int dx, int dy, int dz);
		write_reg(stc_pkg::REG_START_X, 16'(sx)); write_reg(stc_pkg::REG_START_Y, 16'(sy));
		write_reg(stc_pkg::REG_START_Z, 16'(sz));
		write_reg(stc_pkg::REG_SPAN_X, 16'(dx)); write_reg(stc_pkg::REG_SPAN_Y, 16'(dy));
		write_reg(stc_pkg::REG_SPAN_Z, 16'(dz));
	endtask

	// Wait until every request has been answered, then let the pipeline drain.
	task automatic wait_idle();
		while (tri_pending.size() > 0 || crossing_exp.size() > 0 || in_valid)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// Random mesh traffic, mostly triangles placed on the segment.
	task automatic random_traffic(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 50) tri_pending.push_back(placed_tri($urandom_range(1, 255), 0));
			else if (r < 60) tri_pending.push_back(placed_tri($urandom_range(1, 255), 1));
			else if (r < 65) tri_pending.push_back(placed_tri($urandom_range(1, 255), 2));
			else if (r < 70) tri_pending.push_back(placed_tri($urandom_range(0, 1) * 256, 0));
			else if (r < 73) tri_pending.push_back(placed_tri($urandom_range(1, 255), 3));
			else tri_pending.push_back(noise_tri());
		end
	endtask

	initial begin
		tri_t t;
		foreach (seg_reg[i]) seg_reg[i] = '0;
		hit_count = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset segment is a point: everything misses.
		tri_pending.push_back(placed_tri(128, 0));
		wait_idle();

		// Directed: extremes, each special case and a mesh end.
		set_segment(-1000, 500, 200, 3000, -2000, 1500);
		t = noise_tri();
		{t.ax, t.ay, t.az, t.bx, t.by, t.bz, t.cx, t.cy, t.cz} = {9{16'h8000}};
		t.fin = 1'b0;
		tri_pending.push_back(t);
		{t.ax, t.ay, t.az, t.bx, t.by, t.bz, t.cx, t.cy, t.cz} = {9{16'h7FFF}};
		tri_pending.push_back(t);
		t.ax = 16'h8000; t.by = 16'h8000; t.cz = 16'h8000;
		tri_pending.push_back(t);
		tri_pending.push_back(placed_tri(128, 0));
		tri_pending.push_back(placed_tri(1, 0));
		tri_pending.push_back(placed_tri(255, 1));
		tri_pending.push_back(placed_tri(64, 2));
		tri_pending.push_back(placed_tri(0, 0));
		tri_pending.push_back(placed_tri(256, 0));
		tri_pending.push_back(placed_tri(100, 3));
		t = placed_tri(200, 0);
		t.fin = 1'b1;
		tri_pending.push_back(t);
		tri_pending.push_back(placed_tri(30, 0));
		wait_idle();
		write_reg(6, 16'($urandom));
		write_reg(7, 16'($urandom));
		random_traffic(130);
		wait_idle();

		// Extreme segment, with a long output hold-off.
		set_segment(-32768, -32768, -32768, 32767, 32767, 32767);
		hold_req = 1;
		random_traffic(130);
		wait_idle();

		// Zero span.
		set_segment($urandom, $urandom, $urandom, 0, 0, 0);
		random_traffic(40);
		wait_idle();

		// Full-range random segment, part of it with no idling.
		set_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		no_idle = 1;
		random_traffic(60);
		wait_idle();
		no_idle = 0;
		random_traffic(100);
		wait_idle();

		// Short segment at a random start.
		set_segment($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
			$urandom_range(0, 8000) - 4000, $urandom_range(0, 600) - 300,
			$urandom_range(0, 600) - 300, 257);
		random_traffic(130);
		wait_idle();

		// One long mesh of hits, back to back.
		set_segment(-1000, 500, 200, 3000, -2000, 1500);
		no_idle = 1;
		repeat (50) tri_pending.push_back(placed_tri(128, 0));
		foreach (tri_pending[i]) tri_pending[i].fin = 1'b0;
		tri_pending[tri_pending.size() - 1].fin = 1'b1;
		wait_idle();
		no_idle = 0;
		tri_pending.push_back(placed_tri(128, 0));
		wait_idle();

		if (errors == 0)
			$display("PASS segment_triangle_crossing_counter");
		else
			$display("FAIL segment_triangle_crossing_counter");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("FAIL segment_triangle_crossing_counter");
		$finish;
	end

endmodule
